### rtl/core/dfap_pkg.sv
// Shared types and constants of the DHCP free address picker.
// No dependencies; used by the controller, the datapath and the top level.
package dfap_pkg;

    localparam int ADDR_W      = 32;
    localparam int TABLE_DEPTH = 64;
    localparam int OFFERS      = 3;
    localparam int MAX_PREFIX  = 30;

    localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int OFF_W  = $clog2(OFFERS + 1);
    // a contiguous mask with prefix below MAX_PREFIX has an inverse of at least this
    localparam longint MIN_INV = 64'd1 << (ADDR_W - MAX_PREFIX);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 1'd1;

    localparam logic MODE_RECORD  = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [ADDR_W-1:0] MASK_RESET = 32'hFFFF_FF00;

    // result flags as carried in the output tuser
    localparam int UB_OFFER = 0;
    localparam int UB_BAD   = 1;
    localparam int UB_FULL  = 2;
    localparam int USER_W   = 3;

    typedef struct packed {
        logic accept;      // capture the input beat
        logic rec;         // store the captured address, emit the record result
        logic load_bad;    // emit the bad-mask result
        logic walk_init;   // start the host walk after the gateway
        logic scan_start;  // search the table for the current candidate
        logic step;        // candidate found in the table: move on
        logic push;        // candidate is free: hold it, release the held one
        logic fin;         // emit the final result of a request
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;   // output register can take a result this cycle
        logic bad_mask;
        logic cand_ok;     // candidate inside subnet and offers still wanted
        logic scan_done;
        logic scan_hit;
        logic have_pend;   // a free address waits for its last flag
    } t_dp_sts;

endpackage

### rtl/core/dhcp_free_address_picker.sv
// Top level of the DHCP free address picker.
// Depends on dfap_pkg, dfap_ctrl and dfap_dp (which holds the dfap_ram table).

// Keeps a table of up to TABLE_DEPTH (64) addresses already handed out and
// picks free ones. An input beat with tuser low records tdata into the table
// and gives one result beat, with table_full set if the table was already
// full (the address is then dropped; duplicates are stored again). An input
// beat with tuser high asks for offers: if the subnet mask is not a run of
// ones from the top bit or its prefix is 30 or more, one result with
// bad_mask set comes back; otherwise the host numbers after the gateway's
// host part are walked in ascending order and up to three free addresses
// (gateway network part plus host number) are offered, one beat each, tlast
// on the final one. If none is free a single all-zero result with tlast is
// given. Only one input beat is worked on at a time; the next one is taken
// as soon as the previous one's results are all loaded into the output
// register, even while the last result still waits there. For every host
// number examined a request searches the table with one read per stored
// entry, ending early on a match, and at most count + 3 host numbers are
// examined; the table has a single read port. The table needs no clearing
// pass after reset: a fill count marks the valid entries. The user is to
// write configuration (index 0 gateway, index 1 mask) only while the block
// is idle; the block itself does not enforce this.
module dhcp_free_address_picker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [dfap_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfap_pkg::ADDR_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dfap_pkg::ADDR_W-1:0]     s_axis_tdata,  // [31:0] address
    input  logic [0:0]                      s_axis_tuser,  // [0] mode
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dfap_pkg::ADDR_W-1:0]     m_axis_tdata,  // [31:0] offered_address
    output logic [dfap_pkg::USER_W-1:0]     m_axis_tuser,  // [0] offer_valid, [1] bad_mask,
                                                           // [2] table_full
    output logic                            m_axis_tlast   // last result of the input beat
);

    dfap_pkg::t_dp_cmd cmd;
    dfap_pkg::t_dp_sts sts;

    // sequence each input beat: record, or mask check then host walk
    dfap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // configuration registers, address table, walk counters, result register
    dfap_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_addr   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_addr  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

### rtl/core/dfap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dfap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/dfap_ctrl.sv
// Controller of the DHCP free address picker: sequences record and request beats.
// Depends on dfap_pkg; drives the datapath through t_dp_cmd, reads t_dp_sts.
module dfap_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_ready,
    input  dfap_pkg::t_dp_sts i_sts,
    output dfap_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC,
        ST_CHECK,
        ST_CAND,
        ST_SCAN,
        ST_PUSH,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_in_mode == dfap_pkg::MODE_RECORD) ? ST_REC : ST_CHECK;
                end
            end
            ST_REC: begin
                if (i_sts.slot_free) begin
                    o_cmd.rec = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (i_sts.bad_mask) begin
                    if (i_sts.slot_free) begin
                        o_cmd.load_bad = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = ST_CAND;
                end
            end
            ST_CAND: begin
                if (i_sts.cand_ok) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.scan_hit) begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_CAND;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                // the held offer goes out with last low; wait only if there is one
                if (!i_sts.have_pend || i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_CAND;
                end
            end
            ST_FIN: begin
                if (i_sts.slot_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

### rtl/core/dfap_dp.sv
// Datapath of the DHCP free address picker: configuration, table, walk, output register.
// Depends on dfap_pkg and dfap_ram; commanded by dfap_ctrl.
module dfap_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dfap_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfap_pkg::ADDR_W-1:0]     i_cfg_wdata,
    input  logic [dfap_pkg::ADDR_W-1:0]     i_in_addr,
    input  dfap_pkg::t_dp_cmd               i_cmd,
    output dfap_pkg::t_dp_sts               o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [dfap_pkg::ADDR_W-1:0]     o_out_addr,
    output logic [dfap_pkg::USER_W-1:0]     o_out_user,
    output logic                            o_out_last
);

    localparam int AW = dfap_pkg::ADDR_W;

    logic [AW-1:0]                 r_gw;
    logic [AW-1:0]                 r_mask;
    logic [AW-1:0]                 r_in_addr;
    logic [dfap_pkg::CNT_W-1:0]    r_count;
    logic [AW:0]                   r_cur;
    logic [dfap_pkg::OFF_W-1:0]    r_n;
    logic [AW-1:0]                 r_pend;
    logic                          r_have_pend;
    logic [dfap_pkg::CNT_W-1:0]    r_idx;
    logic                          r_cmp_vld;
    logic                          r_scan_busy;
    logic                          r_out_valid;
    logic [AW-1:0]                 r_out_addr;
    logic [dfap_pkg::USER_W-1:0]   r_out_user;
    logic                          r_out_last;

    logic [AW-1:0] inv;
    logic [AW-1:0] inv_inc;
    logic [AW-1:0] cand;
    logic [AW-1:0] rdata;
    logic          full;
    logic          hit_now;
    logic          scan_end;
    logic          slot_free;
    logic          ram_we;

    assign inv       = ~r_mask;
    assign inv_inc   = inv + AW'(1);
    assign cand      = (r_gw & r_mask) | r_cur[AW-1:0];
    assign full      = (r_count >= dfap_pkg::CNT_W'(dfap_pkg::TABLE_DEPTH));
    assign slot_free = !r_out_valid || i_out_ready;
    assign ram_we    = i_cmd.rec && !full;
    assign hit_now   = r_cmp_vld && (rdata == cand);
    assign scan_end  = r_scan_busy && (hit_now || ((r_idx == r_count) && !r_cmp_vld));

    dfap_ram #(
        .WIDTH (AW),
        .DEPTH (dfap_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[dfap_pkg::TBL_AW-1:0]),
        .i_wdata (r_in_addr),
        .i_raddr (r_idx[dfap_pkg::TBL_AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.slot_free = slot_free;
        o_sts.bad_mask  = ((inv & inv_inc) != '0) ||
                          ({1'b0, inv} < (AW+1)'(dfap_pkg::MIN_INV));
        o_sts.cand_ok   = (r_cur <= {1'b0, inv}) &&
                          (r_n < dfap_pkg::OFF_W'(dfap_pkg::OFFERS));
        o_sts.scan_done = scan_end;
        o_sts.scan_hit  = hit_now;
        o_sts.have_pend = r_have_pend;
    end

    // configuration, table fill and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw        <= '0;
            r_mask      <= dfap_pkg::MASK_RESET;
            r_count     <= '0;
            r_have_pend <= 1'b0;
            r_n         <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == dfap_pkg::CFG_GATEWAY)) begin
                r_gw <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == dfap_pkg::CFG_MASK)) begin
                r_mask <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_count <= r_count + dfap_pkg::CNT_W'(1);
            end
            if (i_cmd.walk_init) begin
                r_n         <= '0;
                r_have_pend <= 1'b0;
            end else if (i_cmd.push) begin
                r_n         <= r_n + dfap_pkg::OFF_W'(1);
                r_have_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_addr <= i_in_addr;
        end
        if (i_cmd.walk_init) begin
            r_cur <= {1'b0, r_gw & inv} + (AW+1)'(1);
        end else if (i_cmd.step || i_cmd.push) begin
            r_cur <= r_cur + (AW+1)'(1);
        end
        if (i_cmd.push) begin
            r_pend <= cand;
        end
    end

    // table search: one read issued per cycle, each compared in the cycle after it is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_busy <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_idx       <= '0;
        end else if (i_cmd.scan_start) begin
            r_scan_busy <= 1'b1;
            r_cmp_vld   <= 1'b0;
            r_idx       <= '0;
        end else if (scan_end) begin
            r_scan_busy <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else if (r_scan_busy) begin
            if (r_idx < r_count) begin
                r_idx     <= r_idx + dfap_pkg::CNT_W'(1);
                r_cmp_vld <= 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rec || i_cmd.load_bad || i_cmd.fin ||
                     (i_cmd.push && r_have_pend)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec) begin
            r_out_addr <= '0;
            r_out_user <= dfap_pkg::USER_W'(full) << dfap_pkg::UB_FULL;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_bad) begin
            r_out_addr <= '0;
            r_out_user <= dfap_pkg::USER_W'(1'b1) << dfap_pkg::UB_BAD;
            r_out_last <= 1'b1;
        end else if (i_cmd.fin) begin
            r_out_addr <= r_have_pend ? r_pend : '0;
            r_out_user <= dfap_pkg::USER_W'(r_have_pend) << dfap_pkg::UB_OFFER;
            r_out_last <= 1'b1;
        end else if (i_cmd.push && r_have_pend) begin
            r_out_addr <= r_pend;
            r_out_user <= dfap_pkg::USER_W'(1'b1) << dfap_pkg::UB_OFFER;
            r_out_last <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_addr  = r_out_addr;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dfap_pkg::CNT_W'(dfap_pkg::TABLE_DEPTH))
        else $error("table fill count beyond depth");

    a_offer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= dfap_pkg::OFF_W'(dfap_pkg::OFFERS))
        else $error("more offers held than allowed");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_busy |-> (r_idx <= r_count))
        else $error("table search ran past the fill count");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones(r_out_user) <= 1))
        else $error("result carries more than one kind flag");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rec || i_cmd.load_bad || i_cmd.fin) |-> slot_free)
        else $error("result loaded over one not yet taken");

endmodule
